// ----- design/vjb_pkg.sv -----
// ----------------------------------------------------------------------------
// vjb_pkg
// Shared types and codes for the voice jitter buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package vjb_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] ACT_PRIME   = 2'd0;
    localparam logic [1:0] ACT_PLAY    = 2'd1;
    localparam logic [1:0] ACT_CONCEAL = 2'd2;
    localparam logic [1:0] ACT_STALL   = 2'd3;

    localparam logic [1:0] CFG_PRIME_DEPTH = 2'd0;
    localparam logic [1:0] CFG_DEPTH_CAP   = 2'd1;
    localparam logic [1:0] CFG_JUMP_DEPTH  = 2'd2;

    localparam logic [5:0] RST_PRIME_DEPTH = 6'd3;
    localparam logic [5:0] RST_DEPTH_CAP   = 6'd12;
    localparam logic [5:0] RST_JUMP_DEPTH  = 6'd3;

    typedef struct packed {
        logic        op;
        logic [15:0] seq;
        logic [31:0] tag;
        logic [11:0] length;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [15:0] seq;
        logic [31:0] tag;
        logic [11:0] length;
    } t_slot;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] tag;
        logic [11:0] length;
        logic [15:0] frame_seq;
        logic        jumped;
        logic        reprimed;
    } t_result;

    typedef struct packed {
        logic [5:0] prime_depth;
        logic [5:0] depth_cap;
        logic [5:0] jump_depth;
    } t_cfg;

endpackage

`default_nettype wire

// ----- design/vjb_ram.sv -----
// ----------------------------------------------------------------------------
// vjb_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vjb_ram #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- design/vjb_front.sv -----
// ----------------------------------------------------------------------------
// vjb_front
// Input side: unpacks push/pull transactions into a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vjb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [63:0]   i_s_tdata,   // seq[15:0], payload_tag[47:16], payload_length[59:48]
    input  wire logic          i_s_tuser,   // operation
    input  wire logic          i_hold,
    output logic               o_item_valid,
    output vjb_pkg::t_item     o_item,
    input  wire logic          i_pop
);
    import vjb_pkg::*;

    t_item      r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_in;
    logic       w_push;
    logic       w_pop;

    assign w_in.op     = i_s_tuser;
    assign w_in.seq    = i_s_tdata[15:0];
    assign w_in.tag    = i_s_tdata[47:16];
    assign w_in.length = i_s_tdata[59:48];

    assign o_s_tready   = (r_count != 2'd2) && !i_hold;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_buf[r_rd_ptr];
    assign w_push       = i_s_tvalid && o_s_tready;
    assign w_pop        = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/vjb_back.sv -----
// ----------------------------------------------------------------------------
// vjb_back
// Execution engine: slot ring read-modify-write, priming, jump and stall logic.
// ----------------------------------------------------------------------------
`default_nettype none

module vjb_back #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vjb_pkg::t_cfg  i_cfg,
    input  wire logic           i_item_valid,
    input  wire vjb_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    output vjb_pkg::t_result    o_out,
    input  wire logic           i_out_ready
);
    import vjb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [48:0] MAGIC =
        ((49'd1 << 32) + 49'(RING_DEPTH) - 49'd1) / 49'(RING_DEPTH);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_JUMP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_PWR  = 3'd5;
    localparam logic [2:0] ST_DEC  = 3'd6;

    logic [2:0]    r_state,     n_state;
    logic [AW-1:0] r_clr_addr,  n_clr_addr;
    logic [15:0]   r_play,      n_play;
    logic          r_primed,    n_primed;
    logic [15:0]   r_newest,    n_newest;
    logic          r_known,     n_known;
    logic [FW-1:0] r_filled,    n_filled;
    logic [7:0]    r_stall,     n_stall;
    logic [15:0]   r_key,       n_key;
    logic [15:0]   r_q,         n_q;
    logic [AW-1:0] r_idx,       n_idx;
    t_item         r_item,      n_item;
    logic          r_is_pull,   n_is_pull;
    logic          r_jumped,    n_jumped;
    logic          r_out_valid, n_out_valid;
    t_result       r_out,       n_out;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    t_slot               ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [$bits(t_slot)-1:0] ram_rd_raw;
    t_slot               w_rd;

    logic        w_out_free;
    logic        w_prime_wait;
    logic [15:0] w_lag;
    logic [15:0] w_jump_pos;
    logic [15:0] w_adv;
    logic [15:0] w_rel;
    logic [48:0] w_prod;
    logic [31:0] w_qd;
    logic [15:0] w_rem;
    logic [AW-1:0] w_idx;
    logic        w_hit;
    logic [7:0]  w_stall_inc;

    vjb_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (RING_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_raw)
    );

    assign w_rd = t_slot'(ram_rd_raw);

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_prime_wait = !r_known || (16'(r_filled) < 16'(i_cfg.prime_depth));
    assign w_lag        = r_newest - r_play;
    assign w_jump_pos   = r_newest - 16'(i_cfg.jump_depth);
    assign w_adv        = r_key - r_newest;
    assign w_rel        = r_play - r_newest;
    assign w_prod       = 49'(r_key) * MAGIC;
    assign w_qd         = 32'(r_q) * 32'(RING_DEPTH);
    assign w_rem        = r_key - w_qd[15:0];
    assign w_idx        = w_rem[AW-1:0];
    assign w_hit        = w_rd.valid && (w_rd.seq == r_play);
    assign w_stall_inc  = (r_stall == 8'hFF) ? r_stall : r_stall + 8'd1;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_play      = r_play;
        n_primed    = r_primed;
        n_newest    = r_newest;
        n_known     = r_known;
        n_filled    = r_filled;
        n_stall     = r_stall;
        n_key       = r_key;
        n_q         = r_q;
        n_idx       = r_idx;
        n_item      = r_item;
        n_is_pull   = r_is_pull;
        n_jumped    = r_jumped;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = w_idx;

        unique case (r_state)
            ST_CLR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.op == OP_PUSH) begin
                        o_pop     = 1'b1;
                        n_item    = i_item;
                        n_key     = i_item.seq;
                        n_is_pull = 1'b0;
                        n_state   = ST_MUL;
                    end else if (!r_primed && w_prime_wait) begin
                        if (w_out_free) begin
                            o_pop       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{action: ACT_PRIME, tag: '0, length: '0,
                                            frame_seq: r_play, jumped: 1'b0,
                                            reprimed: 1'b0};
                        end
                    end else begin
                        o_pop     = 1'b1;
                        n_is_pull = 1'b1;
                        if (!r_primed) begin
                            n_play   = r_newest - 16'(i_cfg.prime_depth) + 16'd1;
                            n_primed = 1'b1;
                        end
                        n_state = ST_JUMP;
                    end
                end
            end
            ST_JUMP: begin
                n_jumped = 1'b0;
                n_key    = r_play;
                if (r_known && !w_lag[15] && (w_lag[14:0] > 15'(i_cfg.depth_cap))) begin
                    n_play   = w_jump_pos;
                    n_key    = w_jump_pos;
                    n_jumped = 1'b1;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_q     = w_prod[47:32];
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                ram_rd_en = 1'b1;
                n_idx     = w_idx;
                n_state   = r_is_pull ? ST_DEC : ST_PWR;
            end
            ST_PWR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '{valid: 1'b1, seq: r_key, tag: r_item.tag,
                                length: r_item.length};
                if (!w_rd.valid) begin
                    n_filled = r_filled + FW'(1);
                end
                if (!r_known || (!w_adv[15] && (w_adv != 16'd0))) begin
                    n_newest = r_key;
                    n_known  = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_DEC: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                    n_out.tag       = '0;
                    n_out.length    = '0;
                    n_out.frame_seq = r_play;
                    n_out.jumped    = r_jumped;
                    n_out.reprimed  = 1'b0;
                    if (w_hit) begin
                        n_out.action = ACT_PLAY;
                        n_out.tag    = w_rd.tag;
                        n_out.length = w_rd.length;
                        ram_wr_en    = 1'b1;
                        ram_wr_data  = w_rd;
                        ram_wr_data.valid = 1'b0;
                        if (r_filled != '0) begin
                            n_filled = r_filled - FW'(1);
                        end
                        n_play  = r_play + 16'd1;
                        n_stall = 8'd0;
                    end else if (w_rel[15]) begin
                        n_out.action = ACT_CONCEAL;
                        n_play       = r_play + 16'd1;
                        n_stall      = 8'd0;
                    end else begin
                        n_out.action = ACT_STALL;
                        n_stall      = w_stall_inc;
                        if (w_stall_inc > 8'(i_cfg.depth_cap)) begin
                            n_primed       = 1'b0;
                            n_out.reprimed = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_addr  <= '0;
            r_play      <= '0;
            r_primed    <= 1'b0;
            r_newest    <= '0;
            r_known     <= 1'b0;
            r_filled    <= '0;
            r_stall     <= '0;
            r_is_pull   <= 1'b0;
            r_jumped    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_play      <= n_play;
            r_primed    <= n_primed;
            r_newest    <= n_newest;
            r_known     <= n_known;
            r_filled    <= n_filled;
            r_stall     <= n_stall;
            r_is_pull   <= n_is_pull;
            r_jumped    <= n_jumped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_q    <= n_q;
        r_idx  <= n_idx;
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_clearing  = (r_state == ST_CLR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- design/voice_jitter_buffer_core.sv -----
// ----------------------------------------------------------------------------
// voice_jitter_buffer_core
// Sequence-indexed jitter buffer for one voice peer.
// ----------------------------------------------------------------------------
// Slave stream: tuser = operation (0 push, 1 pull); a push carries seq, tag and
// length in tdata and gives no result, a pull gives exactly one result.
// Master stream: one transaction per pull with action/jumped/reprimed in tuser
// and tag, length and frame sequence in tdata.
// Config channel: i_cfg_index 0 prime_depth, 1 depth_cap, 2 jump_target_depth;
// always ready, index 3 is ignored. Write only while the block is idle.
// A two-entry input queue decouples the slave side from the engine. The engine
// runs one transaction at a time: a push steps through sequence-to-slot
// reciprocal multiply, address, slot read and slot write, a pull adds the
// jump check, a pull answered with priming silence is handled from idle.
// The slot RAM's single read port and read-modify-write set these steps.
// After reset the engine sweeps every slot RAM address with s_tready low. A
// stalled master side holds the result register; pushes keep flowing until a
// pull needs the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_jitter_buffer_core #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,  // seq[15:0], payload_tag[47:16], payload_length[59:48]
    input  wire logic        i_s_tuser,  // operation
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [63:0] o_m_tdata,  // out_tag[31:0], out_length[43:32], frame_seq[59:44]
    output logic      [3:0]  o_m_tuser,  // action[1:0], jumped[2], reprimed[3]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [5:0]  i_cfg_data
);
    import vjb_pkg::*;

    t_cfg    r_cfg;
    logic    w_item_valid;
    t_item   w_item;
    logic    w_pop;
    logic    w_clearing;
    t_result w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prime_depth <= RST_PRIME_DEPTH;
            r_cfg.depth_cap   <= RST_DEPTH_CAP;
            r_cfg.jump_depth  <= RST_JUMP_DEPTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRIME_DEPTH: r_cfg.prime_depth <= i_cfg_data;
                CFG_DEPTH_CAP:   r_cfg.depth_cap   <= i_cfg_data;
                CFG_JUMP_DEPTH:  r_cfg.jump_depth  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vjb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_hold       (w_clearing),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    vjb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_out_valid  (o_m_tvalid),
        .o_out        (w_out),
        .i_out_ready  (i_m_tready)
    );

    assign o_m_tdata = {4'b0, w_out.frame_seq, w_out.length, w_out.tag};
    assign o_m_tuser = {w_out.reprimed, w_out.jumped, w_out.action};

endmodule

`default_nettype wire

// ----- design/vjb_checker.sv -----
// ----------------------------------------------------------------------------
// vjb_checker
// Port-level checks on the result stream of the jitter buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module vjb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] o_m_tdata,
    input wire logic [3:0]  o_m_tuser
);
    import vjb_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1:0] != ACT_PLAY) |-> (o_m_tdata[43:0] == 44'd0))
        else $error("tag/length nonzero without play");

    a_reprime_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3] |-> (o_m_tuser[1:0] == ACT_STALL))
        else $error("reprime without stall");

    a_prime_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1:0] == ACT_PRIME) |-> (o_m_tuser[3:2] == 2'b00))
        else $error("flags set on priming silence");

endmodule

bind voice_jitter_buffer_core vjb_checker u_vjb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
